// File: hdl/arc_pkg.sv
// shared types and constants for the anchor range collector
// used by arc_cell and anchor_range_collector; no dependencies
package arc_pkg;

    // default table size
    localparam int SLOT_COUNT_DEF = 8;

    // field widths
    localparam int NUM_ANCHORS = 3;
    localparam int ANCHOR_W    = 2;
    localparam int TAG_W       = 32;
    localparam int RANGE_W     = 16;
    localparam int TIME_W      = 32;
    localparam int WIN_W       = 16;
    localparam int STATUS_W    = 3;
    localparam int SLOT_OUT_W  = 3;

    localparam logic [WIN_W-1:0]       WINDOW_RESET = 16'd100;
    localparam logic [NUM_ANCHORS-1:0] ALL_PRESENT  = 3'b111;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_RECORDED  = 3'd0,
        ST_DUPLICATE = 3'd1,
        ST_RESTART   = 3'd2,
        ST_NEW       = 3'd3,
        ST_DROPPED   = 3'd4
    } t_status;

    // slot update operations
    typedef enum logic [1:0] {
        OP_NONE,
        OP_START,
        OP_RECORD,
        OP_CLEAR
    } t_slot_op;

    typedef logic [NUM_ANCHORS-1:0][RANGE_W-1:0] t_ranges;

    // search probe handed from cell to cell
    typedef struct packed {
        logic                   valid;
        logic                   match;
        logic                   free;
        logic [NUM_ANCHORS-1:0] present;
        logic [TIME_W-1:0]      last_time;
        t_ranges                ranges;
    } t_probe;

    // slot update command broadcast to all cells
    typedef struct packed {
        t_slot_op          op;
        logic [ANCHOR_W-1:0] anchor;
        logic [RANGE_W-1:0]  range_val;
        logic [TIME_W-1:0]   time_val;
    } t_slot_cmd;

endpackage

// File: hdl/arc_cell.sv
// one slot of the tag table plus one stage of the search chain
// depends on arc_pkg
module arc_cell import arc_pkg::*; #(
    parameter int IDX_W = 3,
    parameter int INDEX = 0
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [TAG_W-1:0] i_tag,
    input  t_probe           i_probe,
    input  logic [IDX_W-1:0] i_match_idx,
    input  logic [IDX_W-1:0] i_free_idx,
    output t_probe           o_probe,
    output logic [IDX_W-1:0] o_match_idx,
    output logic [IDX_W-1:0] o_free_idx,
    input  t_slot_cmd        i_cmd,
    input  logic [IDX_W-1:0] i_cmd_idx
);

    logic                   r_used, n_used;
    logic [NUM_ANCHORS-1:0] r_present, n_present;
    logic [TAG_W-1:0]       r_tag, n_tag;
    logic [TIME_W-1:0]      r_last, n_last;
    t_ranges                r_ranges, n_ranges;
    t_probe                 r_probe, n_probe;
    logic [IDX_W-1:0]       r_match_idx, n_match_idx;
    logic [IDX_W-1:0]       r_free_idx, n_free_idx;
    logic                   w_hit;
    logic [NUM_ANCHORS-1:0] w_bit;

    // probe stage: first used slot with the tag, else first free slot
    always_comb begin
        n_probe     = i_probe;
        n_match_idx = i_match_idx;
        n_free_idx  = i_free_idx;
        if (i_probe.valid) begin
            if (r_used) begin
                if (!i_probe.match && (r_tag == i_tag)) begin
                    n_probe.match     = 1'b1;
                    n_probe.present   = r_present;
                    n_probe.last_time = r_last;
                    n_probe.ranges    = r_ranges;
                    n_match_idx       = IDX_W'(INDEX);
                end
            end else if (!i_probe.free) begin
                n_probe.free = 1'b1;
                n_free_idx   = IDX_W'(INDEX);
            end
        end
    end

    // slot update from the broadcast command
    assign w_hit = (i_cmd.op != OP_NONE) && (i_cmd_idx == IDX_W'(INDEX));
    assign w_bit = NUM_ANCHORS'(1) << i_cmd.anchor;

    always_comb begin
        n_used    = r_used;
        n_present = r_present;
        n_tag     = r_tag;
        n_last    = r_last;
        n_ranges  = r_ranges;
        if (w_hit) begin
            case (i_cmd.op)
                OP_START: begin
                    n_used                   = 1'b1;
                    n_tag                    = i_tag;
                    n_last                   = i_cmd.time_val;
                    n_ranges[i_cmd.anchor]   = i_cmd.range_val;
                    n_present                = w_bit;
                end
                OP_RECORD: begin
                    n_last                   = i_cmd.time_val;
                    n_ranges[i_cmd.anchor]   = i_cmd.range_val;
                    n_present                = r_present | w_bit;
                end
                OP_CLEAR: begin
                    n_used    = 1'b0;
                    n_present = '0;
                end
                default: begin
                    n_used = r_used;
                end
            endcase
        end
    end

    // control state and probe stage register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used    <= 1'b0;
            r_present <= '0;
            r_probe   <= '0;
        end else begin
            r_used    <= n_used;
            r_present <= n_present;
            r_probe   <= n_probe;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_tag             <= n_tag;
        r_last            <= n_last;
        r_ranges          <= n_ranges;
        r_match_idx       <= n_match_idx;
        r_free_idx        <= n_free_idx;
    end

    assign o_probe     = r_probe;
    assign o_match_idx = r_match_idx;
    assign o_free_idx  = r_free_idx;

endmodule

// File: hdl/anchor_range_collector.sv
// top level of the anchor range collector: control, window register, cell chain
// depends on arc_pkg and arc_cell
//
//  channel   dir  handshake                      payload
//  s_axis    in   s_axis_tvalid / s_axis_tready  tdata 80b, tuser 2b
//  m_axis    out  m_axis_tvalid / m_axis_tready  tdata 88b, tuser 4b
//  cfg       in   i_cfg_we                       i_cfg_wdata 16b (window_ms)
//
// one report at a time: the search probe walks the cell chain one cell per cycle,
// then the gathered probe is registered for the decision.
// the result sits in an output register; the next report is taken while
// it waits, and that report stalls before its slot update until the result
// is taken. synchronous active-low reset empties all slots, window = 100.
module anchor_range_collector import arc_pkg::*; #(
    parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    // tag_id [31:0], range_value [47:32], time_ms [79:48]
    input  logic [79:0]      s_axis_tdata,
    // anchor_id [1:0]
    input  logic [1:0]       s_axis_tuser,
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    // slot_index [2:0], done_tag [34:3], range_first [50:35],
    // range_second [66:51], range_third [82:67], zero [87:83]
    output logic [87:0]      m_axis_tdata,
    // status [2:0], complete [3]
    output logic [3:0]       m_axis_tuser,
    input  logic             i_cfg_we,
    input  logic [WIN_W-1:0] i_cfg_wdata
);

    localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LAUNCH,
        S_WAIT,
        S_DECIDE
    } t_state;

    t_state              r_state;
    logic [WIN_W-1:0]    r_window;
    logic [ANCHOR_W-1:0] r_anchor;
    logic [TAG_W-1:0]    r_tag;
    logic [RANGE_W-1:0]  r_range;
    logic [TIME_W-1:0]   r_time;
    t_probe              r_probe;
    logic [IDX_W-1:0]    r_match_idx;
    logic [IDX_W-1:0]    r_free_idx;
    logic                r_out_valid;
    logic [87:0]         r_out_data;
    logic [3:0]          r_out_user;

    t_probe              w_probe     [SLOT_COUNT+1];
    logic [IDX_W-1:0]    w_match_idx [SLOT_COUNT+1];
    logic [IDX_W-1:0]    w_free_idx  [SLOT_COUNT+1];

    t_slot_cmd           w_cmd;
    logic [IDX_W-1:0]    w_cmd_idx;
    logic                w_out_free;
    logic                w_decide;
    logic                w_in_xfer;

    t_status             n_status;
    logic                n_complete;
    logic [IDX_W-1:0]    n_slot;
    t_ranges             n_ranges;
    t_slot_op            n_op;
    logic [ANCHOR_W-1:0] w_a;
    logic [NUM_ANCHORS-1:0] w_bit;
    logic [NUM_ANCHORS-1:0] w_new_present;
    logic [TIME_W-1:0]   w_gap;
    t_ranges             w_merged;

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_in_xfer     = s_axis_tvalid && s_axis_tready;
    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign w_decide      = (r_state == S_DECIDE) && w_out_free;

    // probe enters the head of the chain for one cycle
    always_comb begin
        w_probe[0]       = '0;
        w_probe[0].valid = (r_state == S_LAUNCH);
        w_match_idx[0]   = '0;
        w_free_idx[0]    = '0;
    end

    // chain of slot cells
    for (genvar g = 0; g < SLOT_COUNT; g++) begin : g_cell
        arc_cell #(
            .IDX_W (IDX_W),
            .INDEX (g)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_tag       (r_tag),
            .i_probe     (w_probe[g]),
            .i_match_idx (w_match_idx[g]),
            .i_free_idx  (w_free_idx[g]),
            .o_probe     (w_probe[g+1]),
            .o_match_idx (w_match_idx[g+1]),
            .o_free_idx  (w_free_idx[g+1]),
            .i_cmd       (w_cmd),
            .i_cmd_idx   (w_cmd_idx)
        );
    end

    // decision on the gathered probe
    assign w_a           = r_anchor - ANCHOR_W'(1);
    assign w_bit         = NUM_ANCHORS'(1) << w_a;
    assign w_new_present = r_probe.present | w_bit;
    assign w_gap         = (r_time >= r_probe.last_time) ? (r_time - r_probe.last_time)
                                                         : (r_probe.last_time - r_time);

    always_comb begin
        w_merged = r_probe.ranges;
        w_merged[w_a] = r_range;
    end

    always_comb begin
        n_status   = ST_DROPPED;
        n_complete = 1'b0;
        n_slot     = '0;
        n_ranges   = '0;
        n_op       = OP_NONE;
        if (r_anchor != '0) begin
            if (r_probe.match) begin
                n_slot = r_match_idx;
                if ((r_probe.present & w_bit) != '0) begin
                    n_status = ST_DUPLICATE;
                end else if (w_gap <= TIME_W'(r_window)) begin
                    n_status = ST_RECORDED;
                    if (w_new_present == ALL_PRESENT) begin
                        n_complete = 1'b1;
                        n_ranges   = w_merged;
                        n_op       = OP_CLEAR;
                    end else begin
                        n_op = OP_RECORD;
                    end
                end else begin
                    n_status = ST_RESTART;
                    n_op     = OP_START;
                end
            end else if (r_probe.free) begin
                n_slot   = r_free_idx;
                n_status = ST_NEW;
                n_op     = OP_START;
            end
        end
    end

    // slot update command, issued when the result is loaded
    always_comb begin
        w_cmd.op        = w_decide ? n_op : OP_NONE;
        w_cmd.anchor    = w_a;
        w_cmd.range_val = r_range;
        w_cmd.time_val  = r_time;
        w_cmd_idx       = n_slot;
    end

    // sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_window    <= WINDOW_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_window <= i_cfg_wdata;
            end
            if (w_decide) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_in_xfer) begin
                        r_anchor <= s_axis_tuser;
                        r_tag    <= s_axis_tdata[31:0];
                        r_range  <= s_axis_tdata[47:32];
                        r_time   <= s_axis_tdata[79:48];
                        r_state  <= S_LAUNCH;
                    end
                end
                S_LAUNCH: begin
                    r_state <= S_WAIT;
                end
                S_WAIT: begin
                    if (w_probe[SLOT_COUNT].valid) begin
                        r_probe     <= w_probe[SLOT_COUNT];
                        r_match_idx <= w_match_idx[SLOT_COUNT];
                        r_free_idx  <= w_free_idx[SLOT_COUNT];
                        r_state     <= S_DECIDE;
                    end
                end
                S_DECIDE: begin
                    if (w_out_free) begin
                        r_out_user  <= {n_complete, n_status};
                        r_out_data  <= {5'b0, n_ranges[2], n_ranges[1], n_ranges[0],
                                        r_tag, SLOT_OUT_W'(n_slot)};
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;

endmodule
